FILE: hw/rtl/aesinv_pkg.sv
//==============================================================================
// AES inverse cipher package
// Shared constants, the inverse S-box and the round helper functions.
//==============================================================================
`default_nettype none
package aesinv_pkg;

    localparam int KEY_WORDS  = 60;
    localparam int MAX_ROUNDS = KEY_WORDS / 4 - 1;
    localparam int KIDX_W     = $clog2(KEY_WORDS);
    localparam int RND_W      = 4;
    localparam int QDEPTH     = 2;

    typedef enum logic {
        CMD_LOAD    = 1'b0,
        CMD_DECRYPT = 1'b1
    } t_cmd;

    // Key loads and decrypts share the queue so they are carried out in order.
    typedef struct packed {
        t_cmd              cmd;
        logic [KIDX_W-1:0] kidx;
        logic [31:0]       kword;
        logic [127:0]      block;
        logic [3:0]        nr;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_ROUND,
        ST_DONE
    } t_state;

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Multiplication by the fixed inverse MixColumns coefficients.
    function automatic logic [7:0] mul9(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
        return a8 ^ a;
    endfunction
    function automatic logic [7:0] mulb(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
        return a8 ^ a2 ^ a;
    endfunction
    function automatic logic [7:0] muld(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
        return a8 ^ a4 ^ a;
    endfunction
    function automatic logic [7:0] mule(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
        return a8 ^ a4 ^ a2;
    endfunction

    // State byte n sits at bits [127-8n -: 8].
    function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (c * 4 + r) -: 8] =
                    INV_SBOX[s[127 - 8 * (((c - r + 4) % 4) * 4 + r) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   b0, b1, b2, b3;
        for (int c = 0; c < 4; c++) begin
            b0 = s[127 - 32 * c -: 8];
            b1 = s[119 - 32 * c -: 8];
            b2 = s[111 - 32 * c -: 8];
            b3 = s[103 - 32 * c -: 8];
            t[127 - 32 * c -: 8] = mule(b0) ^ mulb(b1) ^ muld(b2) ^ mul9(b3);
            t[119 - 32 * c -: 8] = mul9(b0) ^ mule(b1) ^ mulb(b2) ^ muld(b3);
            t[111 - 32 * c -: 8] = muld(b0) ^ mul9(b1) ^ mule(b2) ^ mulb(b3);
            t[103 - 32 * c -: 8] = mulb(b0) ^ muld(b1) ^ mul9(b2) ^ mule(b3);
        end
        return t;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/aesinv_front.sv
//==============================================================================
// AES inverse cipher front end
// Accepts items and queues key loads and decrypt jobs in arrival order.
//==============================================================================
`default_nettype none
module aesinv_front
    import aesinv_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 i_cmd,
    input  wire logic [KIDX_W-1:0]    i_key_index,
    input  wire logic [31:0]          i_key_word,
    input  wire logic [63:0]          i_block_hi,
    input  wire logic [63:0]          i_block_lo,
    input  wire logic [RND_W-1:0]     i_num_rounds,
    output logic                      o_job_valid,
    output t_job                      o_job,
    input  wire logic                 i_job_take
);
    localparam int QP_W = $clog2(QDEPTH);

    t_job                r_q [QDEPTH];
    logic [QP_W-1:0]     r_wp, r_rp;
    logic [QP_W:0]       r_cnt;
    logic                acc;
    logic [RND_W-1:0]    nr_sat;

    assign full   = (r_cnt == (QP_W+1)'(QDEPTH)) ? 1'b1 : 1'b0;
    assign acc    = push && !full;
    assign nr_sat = (i_num_rounds > RND_W'(MAX_ROUNDS)) ? RND_W'(MAX_ROUNDS) : i_num_rounds;

    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wp] <= '{cmd: t_cmd'(i_cmd), kidx: i_key_index, kword: i_key_word,
                           block: {i_block_hi, i_block_lo}, nr: nr_sat};
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (acc) r_wp <= r_wp + 1'b1;
            if (i_job_take && o_job_valid) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QP_W+1)'(acc) - (QP_W+1)'(i_job_take && o_job_valid);
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/aesinv_back.sv
//==============================================================================
// AES inverse cipher back end
// Shared round unit with the key store; one round per cycle.
//==============================================================================
`default_nettype none
module aesinv_back
    import aesinv_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_job_valid,
    input  wire t_job                 i_job,
    output logic                      o_job_take,
    output logic                      o_res_valid,
    output logic [127:0]              o_res,
    input  wire logic                 i_res_take
);
    localparam int RA_W = KIDX_W - 2;

    // Key store as four banks, one per column, so a whole round key reads at once.
    logic [31:0]      r_ks0 [KEY_WORDS/4];
    logic [31:0]      r_ks1 [KEY_WORDS/4];
    logic [31:0]      r_ks2 [KEY_WORDS/4];
    logic [31:0]      r_ks3 [KEY_WORDS/4];
    logic [127:0]     r_rk;
    logic [RA_W-1:0]  rk_addr;

    t_state           r_state, n_state;
    logic [127:0]     r_s;
    logic [127:0]     r_res;
    logic             r_res_v;
    logic [RND_W-1:0] r_left;
    logic [RND_W-1:0] r_nr;
    logic             take, last_rnd, key_we;
    logic [127:0]     ss, mixed;

    // A queued key load is written when the unit takes it, after every
    // earlier decrypt has finished reading the store.
    assign key_we = take && (i_job.cmd == CMD_LOAD) && (i_job.kidx < KIDX_W'(KEY_WORDS));

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            unique case (i_job.kidx[1:0])
                2'd0:    r_ks0[i_job.kidx[KIDX_W-1:2]] <= i_job.kword;
                2'd1:    r_ks1[i_job.kidx[KIDX_W-1:2]] <= i_job.kword;
                2'd2:    r_ks2[i_job.kidx[KIDX_W-1:2]] <= i_job.kword;
                default: r_ks3[i_job.kidx[KIDX_W-1:2]] <= i_job.kword;
            endcase
        end
        r_rk <= {r_ks0[rk_addr], r_ks1[rk_addr], r_ks2[rk_addr], r_ks3[rk_addr]};
    end

    // Round key for the next step: start reads row nr, each round one row lower.
    always_comb begin
        if (r_state == ST_FIRST) begin
            rk_addr = (r_nr == '0) ? '0 : RA_W'(r_nr - 1'b1);
        end else if (take) begin
            rk_addr = RA_W'(i_job.nr);
        end else begin
            rk_addr = (r_left <= 4'd1) ? '0 : RA_W'(r_left - 4'd2);
        end
    end

    assign take       = (r_state == ST_IDLE) && i_job_valid;
    assign o_job_take = take;
    assign last_rnd   = (r_left == 4'd1);
    assign ss         = inv_shift_sub(r_s);
    assign mixed      = inv_mix(ss ^ r_rk);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_job_valid && i_job.cmd == CMD_DECRYPT) n_state = ST_FIRST;
            ST_FIRST: n_state = ST_ROUND;
            ST_ROUND: if (last_rnd) n_state = ST_DONE;
            ST_DONE:  if (!r_res_v || i_res_take) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: if (take) begin
                r_s  <= i_job.block;
                r_nr <= i_job.nr;
            end
            ST_FIRST: begin
                // With no middle rounds the final round still runs once.
                r_s    <= r_s ^ r_rk;
                r_left <= (r_nr == '0) ? 4'd1 : r_nr;
            end
            ST_ROUND: begin
                r_s    <= last_rnd ? (ss ^ r_rk) : mixed;
                r_left <= r_left - 4'd1;
            end
            default: ;
        endcase
        if (r_state == ST_DONE && n_state == ST_IDLE) r_res <= r_s;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_res_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && n_state == ST_IDLE) r_res_v <= 1'b1;
            else if (i_res_take) r_res_v <= 1'b0;
        end
    end

    assign o_res_valid = r_res_v;
    assign o_res       = r_res;
endmodule
`default_nettype wire

FILE: hw/rtl/aes_inverse_cipher.sv
//==============================================================================
// AES inverse cipher
// Round-key store, in-order job queue and a shared one-round-per-cycle unit.
//==============================================================================
// Channel   | Handshake             | Payload
// ----------+-----------------------+------------------------------------------
// input     | push / full           | cmd, key_index, key_word, block_hi/lo
// result    | empty / pop           | plain_hi, plain_lo
// config    | cfg_valid / cfg_ready | num_rounds
//
// Key loads and decrypts share the job queue; a key load is written into the
// store when the round unit takes it, and the unit stays in its idle state.
// A decrypt passes the round unit's states in order: the take in idle, the
// first key addition, Nr rounds (one when Nr is zero) and a done state that
// hands the result to the result register, waiting while an earlier result
// is still unread.
// Reset is synchronous, clears control state and sets the round count to 10; key store is not cleared.
// A two-entry job queue lets input transfers continue while the unit works,
// and the result register lets the unit finish while a result waits.
//==============================================================================
`default_nettype none
module aes_inverse_cipher
    import aesinv_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               i_cmd,
    input  wire logic [5:0]         i_key_index,
    input  wire logic [31:0]        i_key_word,
    input  wire logic [63:0]        i_block_hi,
    input  wire logic [63:0]        i_block_lo,
    output logic                    empty,
    input  wire logic               pop,
    output logic [63:0]             o_plain_hi,
    output logic [63:0]             o_plain_lo,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [3:0]         i_num_rounds
);
    logic [RND_W-1:0]  r_num_rounds;
    logic              job_valid, job_take, res_valid;
    logic [127:0]      res;
    t_job              job;

    // The configuration register takes every write.
    assign cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rounds <= 4'd10;
        end else if (cfg_valid) begin
            r_num_rounds <= i_num_rounds;
        end
    end

    aesinv_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_cmd        (i_cmd),
        .i_key_index  (i_key_index),
        .i_key_word   (i_key_word),
        .i_block_hi   (i_block_hi),
        .i_block_lo   (i_block_lo),
        .i_num_rounds (r_num_rounds),
        .o_job_valid  (job_valid),
        .o_job        (job),
        .i_job_take   (job_take)
    );

    aesinv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_take  (job_take),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (pop && res_valid)
    );

    assign empty      = !res_valid;
    assign o_plain_hi = res[127:64];
    assign o_plain_lo = res[63:0];
endmodule
`default_nettype wire

FILE: tb/testbench.sv
//------------------------------------------------------------------------------
// AES inverse cipher testbench
// Fills the round-key store, runs a short directed set of blocks, then random
// key loads and decrypts under several round counts. A scoreboard predicts
// each plaintext and checks every result transfer in order.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
    import aesinv_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 150;

    // Plaintext scoreboard. It keeps its own copy of the key store and of the
    // round count, and predicts every decrypt when its input transfer happens.
    class plaintext_scoreboard;
        bit [31:0]  key_mem [KEY_WORDS];
        bit [3:0]   rounds_reg;
        bit [127:0] pending_plain [$];
        int         errors;

        function new();
            rounds_reg = 4'd10;
            errors     = 0;
        endfunction

        function bit [7:0] gf_mul(bit [7:0] a, bit [7:0] b);
            bit [7:0] acc;
            acc = 8'h00;
            for (int i = 0; i < 8; i++) begin
                if (b[i]) begin
                    acc ^= a;
                end
                a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            end
            return acc;
        endfunction

        // Predicted plaintext of one ciphertext block, byte 0 in the top bits.
        function bit [127:0] decrypt_block(bit [127:0] cipher);
            bit [7:0] st [16];
            bit [7:0] tmp [16];
            bit [7:0] coef [4];
            bit [31:0] w;
            int nr;
            int base;
            int last;
            int rnd;
            coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
            nr = (rounds_reg > MAX_ROUNDS) ? MAX_ROUNDS : rounds_reg;
            for (int n = 0; n < 16; n++) begin
                st[n] = cipher[127 - 8 * n -: 8];
            end
            // Step 0 is the first key addition with group nr; the last step is
            // the final round with group 0, which runs even when nr is zero.
            last = (nr == 0) ? 1 : nr;
            for (int step = 0; step <= last; step++) begin
                rnd = (step == last) ? 0 : nr - step;
                if (step != 0) begin
                    for (int c = 0; c < 4; c++) begin
                        for (int r = 0; r < 4; r++) begin
                            tmp[c * 4 + r] = INV_SBOX[st[((c - r + 4) % 4) * 4 + r]];
                        end
                    end
                    st = tmp;
                end
                base = rnd * 4;
                for (int c = 0; c < 4; c++) begin
                    w = key_mem[base + c];
                    for (int r = 0; r < 4; r++) begin
                        st[c * 4 + r] ^= w[31 - 8 * r -: 8];
                    end
                end
                // Middle rounds end with the inverse column mix.
                if (step != 0 && step != last) begin
                    for (int c = 0; c < 4; c++) begin
                        for (int r = 0; r < 4; r++) begin
                            tmp[c * 4 + r] = 8'h00;
                            for (int k = 0; k < 4; k++) begin
                                tmp[c * 4 + r] ^= gf_mul(coef[(k - r + 4) % 4], st[c * 4 + k]);
                            end
                        end
                    end
                    st = tmp;
                end
            end
            for (int n = 0; n < 16; n++) begin
                cipher[127 - 8 * n -: 8] = st[n];
            end
            return cipher;
        endfunction

        function void note_input(t_cmd cmd, bit [5:0] idx, bit [31:0] word, bit [127:0] blk);
            if (cmd == CMD_LOAD) begin
                // Loads beyond the end of the store are dropped by the block.
                if (idx < KEY_WORDS) begin
                    key_mem[idx] = word;
                end
            end else begin
                pending_plain.push_back(decrypt_block(blk));
            end
        endfunction

        function void report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endfunction

        function void check_result(bit [63:0] hi, bit [63:0] lo);
            bit [127:0] want;
            if (pending_plain.size() == 0) begin
                report($sformatf("unexpected result %h_%h", hi, lo));
                return;
            end
            want = pending_plain.pop_front();
            if (hi !== want[127:64]) begin
                report($sformatf("plain_hi %h, predicted %h", hi, want[127:64]));
            end
            if (lo !== want[63:0]) begin
                report($sformatf("plain_lo %h, predicted %h", lo, want[63:0]));
            end
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        push         = 1'b0;
    logic        full;
    logic        i_cmd        = CMD_LOAD;
    logic [5:0]  i_key_index  = '0;
    logic [31:0] i_key_word   = '0;
    logic [63:0] i_block_hi   = '0;
    logic [63:0] i_block_lo   = '0;
    logic        empty;
    logic        pop          = 1'b0;
    logic [63:0] o_plain_hi;
    logic [63:0] o_plain_lo;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [3:0]  i_num_rounds = 4'd10;

    plaintext_scoreboard sb = new();

    // When set, the matching side runs back to back with no idle cycles.
    bit send_quiet = 1'b0;
    bit pop_quiet  = 1'b0;
    // A request for one long receiver hold-off, counted by the receiver.
    int pop_hold   = 0;
    int idle_count = 0;

    aes_inverse_cipher dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_cmd        (i_cmd),
        .i_key_index  (i_key_index),
        .i_key_word   (i_key_word),
        .i_block_hi   (i_block_hi),
        .i_block_lo   (i_block_lo),
        .empty        (empty),
        .pop          (pop),
        .o_plain_hi   (o_plain_hi),
        .o_plain_lo   (o_plain_lo),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .i_num_rounds (i_num_rounds)
    );

    always #5 i_clk = ~i_clk;

    // Idle length between transfers: mostly none or short, now and then long.
    function automatic int idle_len(bit quiet);
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 50) begin
            return 0;
        end else if (pick < 85) begin
            return $urandom_range(1, 3);
        end else if (pick < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Offer one item and hold it until its transfer. The fields are read by
    // the block only with push, so they stay as they are during idle cycles.
    task automatic send_item(t_cmd cmd, bit [5:0] idx, bit [31:0] word, bit [127:0] blk);
        int gap;
        push        <= 1'b1;
        i_cmd       <= cmd;
        i_key_index <= idx;
        i_key_word  <= word;
        i_block_hi  <= blk[127:64];
        i_block_lo  <= blk[63:0];
        // Signals read right after the edge still hold their pre-edge values.
        do begin
            @(posedge i_clk);
        end while (full);
        sb.note_input(cmd, idx, word, blk);
        gap = idle_len(send_quiet);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_item();
        t_cmd     cmd;
        bit [5:0] idx;
        cmd = ($urandom_range(0, 99) < 75) ? CMD_DECRYPT : CMD_LOAD;
        // A few loads aim past the end of the store and must be dropped.
        idx = ($urandom_range(0, 99) < 92) ? 6'($urandom_range(0, KEY_WORDS - 1))
                                           : 6'($urandom_range(KEY_WORDS, 63));
        send_item(cmd, idx, $urandom, {$urandom, $urandom, $urandom, $urandom});
    endtask

    // Pause the input until every predicted plaintext has come back, then let
    // the round unit settle in case a load was the last thing it saw.
    task automatic drain();
        push <= 1'b0;
        while (sb.pending_plain.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_rounds(bit [3:0] value);
        cfg_valid    <= 1'b1;
        i_num_rounds <= value;
        do begin
            @(posedge i_clk);
        end while (!cfg_ready);
        sb.rounds_reg = value;
        cfg_valid <= 1'b0;
    endtask

    // Result side: pop with random stalls and one long hold-off on request.
    initial begin
        int stall;
        stall = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                sb.check_result(o_plain_hi, o_plain_lo);
                stall = idle_len(pop_quiet);
            end
            if (pop_hold > 0) begin
                stall    = pop_hold;
                pop_hold = 0;
            end
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transfer on any channel.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !i_rst_n) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
            if (idle_count + 1 >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        bit [3:0] round_plan [9];
        round_plan = '{4'd12, 4'd14, 4'd0, 4'd15, 4'd1, 4'd9, 4'd11, 4'd13, 4'd10};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every store entry is written before any decrypt can read it.
        for (int k = 0; k < KEY_WORDS; k++) begin
            send_item(CMD_LOAD, k[5:0], $urandom, {4{$urandom}});
        end

        // Directed items with the reset round count of ten.
        send_item(CMD_LOAD, 6'd5, 32'h0000_0000, {128{1'b1}});
        send_item(CMD_LOAD, 6'd6, 32'hffff_ffff, 128'h0);
        send_item(CMD_LOAD, 6'd60, 32'hdead_beef, 128'h0);
        send_item(CMD_LOAD, 6'd63, 32'hffff_ffff, {128{1'b1}});
        send_item(CMD_DECRYPT, 6'd0, 32'h0, 128'h0);
        send_item(CMD_DECRYPT, 6'd63, 32'hffff_ffff, {128{1'b1}});
        send_item(CMD_DECRYPT, 6'd17, 32'h1234_5678, 128'h69c4e0d86a7b0430d8cdb78070b4c55a);
        send_item(CMD_DECRYPT, 6'd0, 32'h0, 128'h8000_0000_0000_0000_0000_0000_0000_0001);
        // A load in the middle of a burst of decrypts changes only later ones.
        send_item(CMD_LOAD, 6'd0, 32'h0f0f_f0f0, 128'h0);
        send_item(CMD_DECRYPT, 6'd0, 32'h0, 128'hf0f0_0f0f_f0f0_0f0f_f0f0_0f0f_f0f0_0f0f);
        send_item(CMD_LOAD, 6'd40, 32'hffff_ffff, 128'h0);
        send_item(CMD_DECRYPT, 6'd0, 32'h0, {4{$urandom}});
        drain();

        for (int p = 0; p < 9; p++) begin
            write_rounds(round_plan[p]);
            // Short fixed-round-count check on the extremes before random items.
            send_item(CMD_DECRYPT, 6'd0, 32'h0, 128'h0);
            send_item(CMD_DECRYPT, 6'd0, 32'h0, {128{1'b1}});
            if (p == 1) begin
                // Stall the result side for a long stretch while the input
                // keeps offering back to back, so the block fills and stalls.
                pop_hold   = 400;
                send_quiet = 1'b1;
                repeat (30) send_random_item();
                send_quiet = 1'b0;
            end
            pop_quiet = (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_quiet = (n >= 60 && n < 90);
                send_random_item();
            end
            send_quiet = 1'b0;
            pop_quiet  = 1'b0;
            drain();
        end

        if (sb.errors == 0 && sb.pending_plain.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/aesinv_pkg.sv
hw/rtl/aesinv_front.sv
hw/rtl/aesinv_back.sv
hw/rtl/aes_inverse_cipher.sv
tb/testbench.sv
